>>> rtl/indexed_insert_delete_array_defines.svh
// assertion macros for the indexed insert/delete array checker
// no dependencies; included by the checker file only
`ifndef INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_DELETE_ARRAY_DEFINES_SVH

// property checked only while out of reset
`define IIDA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iida assertion failed");

// property checked at every edge, reset included
`define IIDA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("iida assertion failed");

`endif

>>> rtl/iida_pkg.sv
// shared types and codes for the indexed insert/delete array
// no dependencies; imported by every module of the block
package iida_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND  = 3'd0,
        KIND_INSERT  = 3'd1,
        KIND_READ    = 3'd2,
        KIND_REMOVE  = 3'd3,
        KIND_REPLACE = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;        // cell at target takes the new word
        logic shift_up;    // cells above target up to fill take left neighbor
        logic shift_down;  // cells from target below fill-1 take right neighbor
    } t_cell_op;

endpackage

>>> rtl/iida_cell.sv
// one storage cell of the array row: holds a word, loads or shifts
// depends on iida_pkg (t_cell_op)
module iida_cell
    import iida_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int CMP_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CMP_W-1:0]      i_target,
    input  logic [CMP_W-1:0]      i_fill,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  logic [WORD_WIDTH-1:0] i_left,
    input  logic [WORD_WIDTH-1:0] i_right,
    output logic [WORD_WIDTH-1:0] o_word
);

    localparam logic [CMP_W-1:0] MY_IDX   = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] NEXT_IDX = CMP_W'(INDEX + 1);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        priority if (i_op.load && (i_target == MY_IDX)) begin
            n_word = i_word;
        end else if (i_op.shift_up && (MY_IDX > i_target) && (MY_IDX <= i_fill)) begin
            n_word = i_left;
        end else if (i_op.shift_down && (MY_IDX >= i_target) && (NEXT_IDX < i_fill)) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

>>> rtl/indexed_insert_delete_array.sv
// top level of the indexed insert/delete array: control, cell row, result register
// depends on iida_pkg and iida_cell
//
// usage:
//   requests enter on the slave stream: tuser carries the request kind
//   (append, insert, read, remove, replace), tdata the position and word.
//   each request yields exactly one result on the master stream: status
//   (ok, index out of range, full), the word read and the count after it.
//   the words sit in a row of CAPACITY cells; an insert or remove moves
//   every affected cell to its neighbor in the same cycle, so one item is
//   accepted per cycle while the receiver keeps up.
//   the result shows on o_m_tvalid in the cycle after acceptance.
//   the result register is the only buffer: while a result waits, a new
//   item is accepted only in a cycle where the receiver takes the old one,
//   so a stalled receiver stalls the slave side after one result.
//   reset (synchronous, active low) empties the array and drops any
//   pending result; word contents are not cleared and need no clearing,
//   since only positions below the count are ever read.
//   positions and counts travel as 5 bits; words as 32 bits, of which the
//   low WORD_WIDTH are stored.
module indexed_insert_delete_array
    import iida_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [4:0] position, [36:5] word_in, rest zero
    input  logic [KIND_W-1:0]    i_s_tuser,   // [2:0] kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // [1:0] status, [33:2] word_out,
                                              // [38:34] count, rest zero
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      n_fill;
    logic                  r_m_valid;
    t_status               r_status;
    logic [DATA_W-1:0]     r_word_out;
    logic [COUNT_W-1:0]    r_count;

    logic                  w_accept;
    t_kind                 w_kind;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_fill;
    logic [WORD_WIDTH-1:0] w_word;
    logic                  w_full;
    logic [CMP_W-1:0]      w_target;
    t_cell_op              w_op;
    t_cell_op              w_op_gated;
    t_status               w_status;
    logic                  w_do_read;
    logic [WORD_WIDTH-1:0] w_rd;
    logic [WORD_WIDTH-1:0] w_cell_q [CAPACITY];

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_m_valid || i_m_tready;

    assign w_kind = t_kind'(i_s_tuser[KIND_W-1:0]);
    assign w_pos  = CMP_W'(i_s_tdata[POS_W-1:0]);
    assign w_word = WORD_WIDTH'(i_s_tdata[POS_W +: DATA_W]);
    assign w_fill = CMP_W'(r_fill);
    assign w_full = (r_fill == CAP_CNT);

    // request decode
    always_comb begin
        w_op      = '0;
        w_status  = ST_OK;
        w_target  = w_pos;
        w_do_read = 1'b0;
        n_fill    = r_fill;
        unique case (w_kind)
            KIND_APPEND: begin
                w_target = w_fill;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.load = 1'b1;
                    n_fill    = r_fill + CNT_W'(1);
                end
            end
            KIND_INSERT: begin
                // index check comes before the full check
                priority if (w_pos > w_fill) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.load     = 1'b1;
                    w_op.shift_up = 1'b1;
                    n_fill        = r_fill + CNT_W'(1);
                end
            end
            KIND_READ: begin
                if (w_pos >= w_fill) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_read = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (w_pos >= w_fill) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op.shift_down = 1'b1;
                    n_fill          = r_fill - CNT_W'(1);
                end
            end
            KIND_REPLACE: begin
                if (w_pos >= w_fill) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op.load = 1'b1;
                end
            end
            default: begin
                // unused kinds leave everything as is
            end
        endcase
    end

    assign w_op_gated = w_accept ? w_op : '0;

    // read select over the row, one-hot on position
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_pos == CMP_W'(i)) begin
                w_rd = w_rd | w_cell_q[i];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_row
        logic [WORD_WIDTH-1:0] w_left;
        logic [WORD_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell_q[g];
        end else begin : g_mid_l
            assign w_left = w_cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_q[g];
        end else begin : g_mid_r
            assign w_right = w_cell_q[g+1];
        end

        iida_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_op     (w_op_gated),
            .i_target (w_target),
            .i_fill   (w_fill),
            .i_word   (w_word),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_word   (w_cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill    <= n_fill;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= w_status;
            r_word_out <= w_do_read ? DATA_W'(w_rd) : '0;
            r_count    <= COUNT_W'(n_fill);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {
        {(M_TDATA_W - STATUS_W - DATA_W - COUNT_W){1'b0}},
        r_count, r_word_out, r_status
    };

endmodule

>>> rtl/iida_checker.sv
// port-level checker for the indexed insert/delete array, bound to the top level
// depends on iida_pkg and indexed_insert_delete_array_defines.svh
`include "indexed_insert_delete_array_defines.svh"

module iida_checker
    import iida_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [STATUS_W-1:0] w_status;
    logic [DATA_W-1:0]   w_word_out;
    logic [COUNT_W-1:0]  w_count;

    assign w_status   = o_m_tdata[STATUS_W-1:0];
    assign w_word_out = o_m_tdata[STATUS_W +: DATA_W];
    assign w_count    = o_m_tdata[STATUS_W + DATA_W +: COUNT_W];

    // reset drops any pending result
    `IIDA_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_tvalid)

    // every accepted item shows a result on the next cycle
    `IIDA_ASSERT(a_accept_result, i_clk, i_rst_n,
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)

    // an error never carries a word
    `IIDA_ASSERT(a_err_word_zero, i_clk, i_rst_n,
        (o_m_tvalid && w_status != ST_OK) |-> (w_word_out == '0))

    `IIDA_ASSERT(a_count_bound, i_clk, i_rst_n,
        o_m_tvalid |-> (32'(w_count) <= 32'(CAPACITY)))

    `IIDA_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))

endmodule

bind indexed_insert_delete_array iida_checker #(
    .CAPACITY (CAPACITY)
) u_iida_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> verif/iida_tb_pkg.sv
`timescale 1ns / 100ps
// array shadow for the indexed insert/delete array testbench: predicts each result
// and compares accepted results in order; depends on iida_pkg
package iida_tb_pkg;
    import iida_pkg::*;

    localparam int SHADOW_DEPTH = 16;

    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
    } t_array_result;

    class array_shadow;
        logic [DATA_W-1:0] words [SHADOW_DEPTH];
        int unsigned       fill;
        t_array_result     expected_results [$];
        int unsigned       errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        // apply one accepted request to the shadow and queue its result
        function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] word);
            t_array_result res;
            int i;
            res.status = ST_OK;
            res.word = '0;
            case (kind)
                KIND_APPEND: begin
                    if (fill >= SHADOW_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        words[fill] = word;
                        fill++;
                    end
                end
                KIND_INSERT: begin
                    // index is checked before fullness
                    if (pos > fill) begin
                        res.status = ST_RANGE;
                    end else if (fill >= SHADOW_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = fill; i > pos; i--) words[i] = words[i-1];
                        words[pos] = word;
                        fill++;
                    end
                end
                KIND_READ: begin
                    if (pos >= fill) res.status = ST_RANGE;
                    else res.word = words[pos];
                end
                KIND_REMOVE: begin
                    if (pos >= fill) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = pos; i + 1 < fill; i++) words[i] = words[i+1];
                        fill--;
                    end
                end
                KIND_REPLACE: begin
                    if (pos >= fill) res.status = ST_RANGE;
                    else words[pos] = word;
                end
                default: begin
                    // spare kinds leave everything as it is
                end
            endcase
            res.count = fill[COUNT_W-1:0];
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_array_result exp_res;
            logic [STATUS_W-1:0] act_status;
            logic [DATA_W-1:0]   act_word;
            logic [COUNT_W-1:0]  act_count;
            act_status = tdata[STATUS_W-1:0];
            act_word = tdata[STATUS_W +: DATA_W];
            act_count = tdata[STATUS_W+DATA_W +: COUNT_W];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d word %h count %0d",
                         $time, act_status, act_word, act_count);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (act_status !== exp_res.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, exp_res.status, act_status);
                errors++;
            end
            if (act_word !== exp_res.word) begin
                $display("%0t: word mismatch, expected %h, got %h",
                         $time, exp_res.word, act_word);
                errors++;
            end
            if (act_count !== exp_res.count) begin
                $display("%0t: count mismatch, expected %0d, got %0d",
                         $time, exp_res.count, act_count);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// top of the indexed insert/delete array testbench: clock, reset, stream drivers
// and result monitor; depends on iida_pkg, iida_tb_pkg and the block itself
module tb_top;
    import iida_pkg::*;
    import iida_tb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_LEN = 50;
    localparam int PHASE_ITEMS = 112;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    array_shadow shadow;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    bit          hold_off_req;
    int unsigned cycle_count;

    indexed_insert_delete_array dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL indexed_insert_delete_array");
            $finish;
        end
    end

    // results are checked before the request of the same edge is noted
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) shadow.check_result(m_tdata);
            if (s_tvalid && s_tready) begin
                shadow.note_request(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W +: DATA_W]);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN - 1) begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(S_TDATA_W-POS_W-DATA_W){1'b0}}, word, pos};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // grow leans on append/insert, shrink on remove; positions mostly in range
    task automatic send_random(input bit grow);
        int unsigned roll;
        int unsigned fill_now;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        fill_now = shadow.fill;
        roll = $urandom_range(99);
        if (roll < 5) kind = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        else if (roll < (grow ? 35 : 15)) kind = KIND_APPEND;
        else if (roll < (grow ? 65 : 25)) kind = KIND_INSERT;
        else if (roll < (grow ? 78 : 45)) kind = KIND_READ;
        else if (roll < (grow ? 88 : 85)) kind = KIND_REMOVE;
        else kind = KIND_REPLACE;
        if ($urandom_range(99) < 85) begin
            if (kind == KIND_INSERT) pos = POS_W'($urandom_range(fill_now, 0));
            else if (fill_now == 0) pos = '0;
            else pos = POS_W'($urandom_range(fill_now - 1, 0));
        end else begin
            pos = POS_W'($urandom_range(POS_MAX, 0));
        end
        roll = $urandom_range(99);
        if (roll < 8) word = '0;
        else if (roll < 16) word = '1;
        else word = $urandom;
        send_item(kind, pos, word);
    endtask

    // stop offering and wait until every queued result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        // empty array: read, remove, replace and insert at 1 are out of range
        send_item(KIND_READ, 0, '0);
        send_item(KIND_REMOVE, 0, '0);
        send_item(KIND_REPLACE, 0, 32'hdead_beef);
        send_item(KIND_INSERT, 1, 32'h1111_1111);
        send_item(KIND_INSERT, 0, '1);
        send_item(KIND_APPEND, 0, '0);
        send_item(KIND_INSERT, 1, 32'h1234_5678);
        // position equal to the count inserts at the end
        send_item(KIND_INSERT, 3, 32'h8000_0001);
        send_item(KIND_READ, 3, '0);
        send_item(KIND_REPLACE, 2, 32'h5a5a_a5a5);
        send_item(KIND_REMOVE, 0, '0);
        send_item(KIND_SPARE_LO, POS_W'(POS_MAX), '1);
        send_item(KIND_SPARE_HI, 0, 32'h0f0f_0f0f);
        while (shadow.fill < SHADOW_DEPTH - 1) send_item(KIND_APPEND, 0, $urandom);
        drain();
        send_item(KIND_APPEND, 0, 32'hcafe_0001);
        // full array: append and insert report full, index check comes first
        send_item(KIND_APPEND, 0, 32'hcafe_0002);
        send_item(KIND_INSERT, POS_W'(SHADOW_DEPTH + 1), '1);
        send_item(KIND_INSERT, POS_W'(SHADOW_DEPTH), '1);
        send_item(KIND_INSERT, 0, '1);
        send_item(KIND_READ, POS_W'(SHADOW_DEPTH - 1), '0);
        send_item(KIND_READ, POS_W'(SHADOW_DEPTH), '0);
        send_item(KIND_REMOVE, POS_W'(SHADOW_DEPTH - 1), '0);
        send_item(KIND_REMOVE, 0, '0);
        send_item(KIND_REPLACE, POS_W'(POS_MAX), '1);
    endtask

    initial begin
        shadow = new();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while items keep coming
                if (phase == 0 && n == 20) hold_off_req = 1'b1;
                send_random(((n / 28) % 2) == 0);
            end
            drain();
        end

        repeat (4) @(posedge clk);
        if (shadow.errors == 0 && shadow.expected_results.size() == 0) begin
            $display("PASS indexed_insert_delete_array");
        end else begin
            $display("FAIL indexed_insert_delete_array");
        end
        $finish;
    end

endmodule
